// File: src/scu_pkg.sv
`timescale 1ns / 1ps

package scu_pkg;

    // Order in which one buffered input frame releases its results
    localparam logic [1:0] SLOT_MID     = 2'd0;  // midpoint between the two previous frames
    localparam logic [1:0] SLOT_PREV    = 2'd1;  // previous original frame
    localparam logic [1:0] SLOT_END_MID = 2'd2;  // linear midpoint closing the buffer
    localparam logic [1:0] SLOT_LAST   = 2'd3;   // current frame, marked last

    // Frames seen in the buffer, saturating
    localparam logic [1:0] FRAMES_NONE  = 2'd0;
    localparam logic [1:0] FRAMES_ONE   = 2'd1;
    localparam logic [1:0] FRAMES_TWO   = 2'd2;
    localparam logic [1:0] FRAMES_MANY  = 2'd3;

    typedef struct packed {
        logic [1:0] frames;
        logic       eob;
    } t_item_ctl;

endpackage

// File: src/scu_interp.sv
`timescale 1ns / 1ps

module scu_interp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic signed [SAMPLE_BITS-1:0] i_c,
    input  logic signed [SAMPLE_BITS-1:0] i_d,
    input  logic                          i_cubic,
    output logic signed [SAMPLE_BITS-1:0] o_mid
);
    localparam int W  = SAMPLE_BITS;
    localparam int SW = SAMPLE_BITS + 6;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [W:0]    w_lin_sum;
    logic signed [SW-1:0] w_bc;
    logic signed [SW-1:0] w_ad;
    logic signed [SW-1:0] w_nine_bc;
    logic signed [SW-1:0] w_diff;
    logic signed [SW-1:0] w_shifted;
    logic signed [W-1:0]  w_cubic;

    // (b+c)>>1, floor: drop the low bit of the widened sum
    assign w_lin_sum = {i_b[W-1], i_b} + {i_c[W-1], i_c};

    // (9*(b+c) - (a+d)) >>> 4 with saturation
    assign w_bc      = SW'(i_b) + SW'(i_c);
    assign w_ad      = SW'(i_a) + SW'(i_d);
    assign w_nine_bc = (w_bc <<< 3) + w_bc;
    assign w_diff    = w_nine_bc - w_ad;
    assign w_shifted = w_diff >>> 4;

    always_comb begin
        if (w_shifted > SAT_HI) begin
            w_cubic = SAT_HI[W-1:0];
        end else if (w_shifted < SAT_LO) begin
            w_cubic = SAT_LO[W-1:0];
        end else begin
            w_cubic = w_shifted[W-1:0];
        end
    end

    assign o_mid = i_cubic ? w_cubic : w_lin_sum[W:1];

endmodule

// File: src/scu_front.sv
`timescale 1ns / 1ps

module scu_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic                          i_eob,
    input  logic                          i_item_done,
    output logic                          o_item_valid,
    output scu_pkg::t_item_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_cur_l,
    output logic signed [SAMPLE_BITS-1:0] o_h0_l,
    output logic signed [SAMPLE_BITS-1:0] o_h1_l,
    output logic signed [SAMPLE_BITS-1:0] o_h2_l,
    output logic signed [SAMPLE_BITS-1:0] o_cur_r,
    output logic signed [SAMPLE_BITS-1:0] o_h0_r,
    output logic signed [SAMPLE_BITS-1:0] o_h1_r,
    output logic signed [SAMPLE_BITS-1:0] o_h2_r
);
    import scu_pkg::*;

    localparam int W = SAMPLE_BITS;

    logic            w_accept;
    logic            r_item_valid;
    logic [1:0]      r_frames;
    logic [1:0]      n_frames;
    logic [W-1:0]    r_hist_l [3];
    logic [W-1:0]    r_hist_r [3];
    t_item_ctl       r_ctl;
    logic [W-1:0]    r_cur_l;
    logic [W-1:0]    r_cur_r;
    logic [W-1:0]    r_snap_l [3];
    logic [W-1:0]    r_snap_r [3];

    // A new frame may enter as the held one releases its final result
    assign o_ready  = !r_item_valid || i_item_done;
    assign w_accept = i_valid && o_ready;
    assign n_frames = (r_frames == FRAMES_MANY) ? FRAMES_MANY : r_frames + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_frames     <= FRAMES_NONE;
            for (int i = 0; i < 3; i++) begin
                r_hist_l[i] <= '0;
                r_hist_r[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_item_valid <= 1'b1;
            end else if (i_item_done) begin
                r_item_valid <= 1'b0;
            end
            if (w_accept) begin
                if (i_eob) begin
                    // close the buffer: start the next one from a clean history
                    r_frames <= FRAMES_NONE;
                    for (int i = 0; i < 3; i++) begin
                        r_hist_l[i] <= '0;
                        r_hist_r[i] <= '0;
                    end
                end else begin
                    r_frames    <= n_frames;
                    r_hist_l[2] <= r_hist_l[1];
                    r_hist_l[1] <= r_hist_l[0];
                    r_hist_l[0] <= i_left;
                    r_hist_r[2] <= r_hist_r[1];
                    r_hist_r[1] <= r_hist_r[0];
                    r_hist_r[0] <= i_right;
                end
            end
        end
    end

    // Snapshot of the frame and the history it sees
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctl.frames <= r_frames;
            r_ctl.eob    <= i_eob;
            r_cur_l      <= i_left;
            r_cur_r      <= i_right;
            for (int i = 0; i < 3; i++) begin
                r_snap_l[i] <= r_hist_l[i];
                r_snap_r[i] <= r_hist_r[i];
            end
        end
    end

    assign o_item_valid = r_item_valid;
    assign o_ctl        = r_ctl;
    assign o_cur_l      = r_cur_l;
    assign o_h0_l       = r_snap_l[0];
    assign o_h1_l       = r_snap_l[1];
    assign o_h2_l       = r_snap_l[2];
    assign o_cur_r      = r_cur_r;
    assign o_h0_r       = r_snap_r[0];
    assign o_h1_r       = r_snap_r[1];
    assign o_h2_r       = r_snap_r[2];

    a_fresh_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames == FRAMES_NONE) |-> (r_hist_l[0] == '0 && r_hist_l[1] == '0 &&
            r_hist_l[2] == '0 && r_hist_r[0] == '0 && r_hist_r[1] == '0 &&
            r_hist_r[2] == '0))
        else $error("history not clear at buffer start");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_item_valid)
        else $error("input stalled with no frame held");

endmodule

// File: src/scu_seq.sv
`timescale 1ns / 1ps

module scu_seq #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  scu_pkg::t_item_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_l,
    input  logic signed [SAMPLE_BITS-1:0] i_h0_l,
    input  logic signed [SAMPLE_BITS-1:0] i_h1_l,
    input  logic signed [SAMPLE_BITS-1:0] i_h2_l,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_r,
    input  logic signed [SAMPLE_BITS-1:0] i_h0_r,
    input  logic signed [SAMPLE_BITS-1:0] i_h1_r,
    input  logic signed [SAMPLE_BITS-1:0] i_h2_r,
    output logic                          o_item_done,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_is_midpoint,
    output logic                          o_last_of_buffer
);
    import scu_pkg::*;

    localparam int W = SAMPLE_BITS;

    logic [1:0]          r_step;
    logic [1:0]          w_slot;
    logic [1:0]          w_last_slot;
    logic                w_has;
    logic                w_load_ok;
    logic                w_load;
    logic                w_at_mid;
    logic                w_cubic;
    logic signed [W-1:0] w_b_l, w_c_l, w_mid_l;
    logic signed [W-1:0] w_b_r, w_c_r, w_mid_r;
    logic                r_out_valid;
    logic signed [W-1:0] r_out_l;
    logic signed [W-1:0] r_out_r;
    logic                r_out_mid;
    logic                r_out_last;

    // Without two frames of history there is no leading midpoint
    assign w_slot      = r_step + ((i_ctl.frames == FRAMES_TWO ||
                                    i_ctl.frames == FRAMES_MANY) ? 2'd0 : 2'd1);
    assign w_last_slot = i_ctl.eob ? SLOT_LAST : SLOT_PREV;
    assign w_has       = (i_ctl.frames != FRAMES_NONE);
    assign w_load_ok   = !r_out_valid || i_ready;
    assign w_load      = i_item_valid && w_has && w_load_ok;
    assign o_item_done = i_item_valid && (!w_has || (w_load_ok && w_slot == w_last_slot));

    assign w_at_mid = (w_slot == SLOT_MID);
    assign w_cubic  = w_at_mid && (i_ctl.frames == FRAMES_MANY);
    assign w_b_l    = w_at_mid ? i_h1_l : i_h0_l;
    assign w_c_l    = w_at_mid ? i_h0_l : i_cur_l;
    assign w_b_r    = w_at_mid ? i_h1_r : i_h0_r;
    assign w_c_r    = w_at_mid ? i_h0_r : i_cur_r;

    scu_interp #(.SAMPLE_BITS(SAMPLE_BITS)) u_interp_l (
        .i_a     (i_h2_l),
        .i_b     (w_b_l),
        .i_c     (w_c_l),
        .i_d     (i_cur_l),
        .i_cubic (w_cubic),
        .o_mid   (w_mid_l)
    );

    scu_interp #(.SAMPLE_BITS(SAMPLE_BITS)) u_interp_r (
        .i_a     (i_h2_r),
        .i_b     (w_b_r),
        .i_c     (w_c_r),
        .i_d     (i_cur_r),
        .i_cubic (w_cubic),
        .o_mid   (w_mid_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_done) begin
                r_step <= 2'd0;
            end else if (w_load) begin
                r_step <= r_step + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            case (w_slot)
                SLOT_MID: begin
                    r_out_l    <= w_mid_l;
                    r_out_r    <= w_mid_r;
                    r_out_mid  <= 1'b1;
                    r_out_last <= 1'b0;
                end
                SLOT_PREV: begin
                    r_out_l    <= i_h0_l;
                    r_out_r    <= i_h0_r;
                    r_out_mid  <= 1'b0;
                    r_out_last <= 1'b0;
                end
                SLOT_END_MID: begin
                    r_out_l    <= w_mid_l;
                    r_out_r    <= w_mid_r;
                    r_out_mid  <= 1'b1;
                    r_out_last <= 1'b0;
                end
                SLOT_LAST: begin
                    r_out_l    <= i_cur_l;
                    r_out_r    <= i_cur_r;
                    r_out_mid  <= 1'b0;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_l    <= i_cur_l;
                    r_out_r    <= i_cur_r;
                    r_out_mid  <= 1'b0;
                    r_out_last <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_left       = r_out_l;
    assign o_out_right      = r_out_r;
    assign o_is_midpoint    = r_out_mid;
    assign o_last_of_buffer = r_out_last;

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && w_has) |-> (w_slot <= w_last_slot))
        else $error("result slot ran past the end of the frame");

    a_done_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_done |-> i_item_valid)
        else $error("frame released while none is held");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_valid)
        else $error("loaded result not presented");

    a_last_is_original: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_buffer) |-> !o_is_midpoint)
        else $error("buffer end marked on a midpoint");

endmodule

// File: src/stereo_2x_cubic_upsampler.sv
`timescale 1ns / 1ps

// Stereo 2x upsampler with cubic midpoints and linear buffer edges.
// Input channel: i_valid / o_ready carries one stereo frame per transaction
// plus an end-of-buffer flag. Output channel: o_valid / i_ready carries one
// output frame per transaction, tagged as midpoint or original and marked on
// the final frame of the buffer.
// Frames are released one step late: a frame's results come out when the
// following frame arrives, and the end-of-buffer frame flushes the rest.
// Each accepted frame is held in the front register and each result in
// the single output register. A frame yields 0 to 4 results, emitted one
// per cycle while i_ready is high, so a steady stream gives two results
// per frame and an end-of-buffer frame gives up to four.
// A new frame is taken in the cycle its predecessor releases its final
// result, while that result may still wait in the output register.
// When i_ready is low the output register holds its frame and, while the
// held input frame still has a result to load, o_ready drops.
// Reset clears history, the frame count and both valid flags.
module stereo_2x_cubic_upsampler #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                          i_end_of_buffer,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_is_midpoint,
    output logic                          o_last_of_buffer
);
    import scu_pkg::*;

    logic                          w_item_valid;
    logic                          w_item_done;
    t_item_ctl                     w_ctl;
    logic signed [SAMPLE_BITS-1:0] w_cur_l, w_h0_l, w_h1_l, w_h2_l;
    logic signed [SAMPLE_BITS-1:0] w_cur_r, w_h0_r, w_h1_r, w_h2_r;

    scu_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_left       (i_left_sample),
        .i_right      (i_right_sample),
        .i_eob        (i_end_of_buffer),
        .i_item_done  (w_item_done),
        .o_item_valid (w_item_valid),
        .o_ctl        (w_ctl),
        .o_cur_l      (w_cur_l),
        .o_h0_l       (w_h0_l),
        .o_h1_l       (w_h1_l),
        .o_h2_l       (w_h2_l),
        .o_cur_r      (w_cur_r),
        .o_h0_r       (w_h0_r),
        .o_h1_r       (w_h1_r),
        .o_h2_r       (w_h2_r)
    );

    scu_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (w_item_valid),
        .i_ctl            (w_ctl),
        .i_cur_l          (w_cur_l),
        .i_h0_l           (w_h0_l),
        .i_h1_l           (w_h1_l),
        .i_h2_l           (w_h2_l),
        .i_cur_r          (w_cur_r),
        .i_h0_r           (w_h0_r),
        .i_h1_r           (w_h1_r),
        .i_h2_r           (w_h2_r),
        .o_item_done      (w_item_done),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_left       (o_out_left),
        .o_out_right      (o_out_right),
        .o_is_midpoint    (o_is_midpoint),
        .o_last_of_buffer (o_last_of_buffer)
    );

endmodule
